>>> rtl/core/dmtc_pkg.sv
// shared constants, types and helpers for the ttl verdict cache
// used by every file of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dmtc_pkg;

  localparam int unsigned MAX_SLOTS  = 2048;
  localparam int unsigned MIN_SLOTS  = 64;
  localparam int unsigned SLOT_W     = $clog2(MAX_SLOTS);
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned WORD_W     = $clog2(KEY_WORDS);
  localparam int unsigned KEY_DEPTH  = MAX_SLOTS * KEY_WORDS;
  localparam int unsigned KEY_AW     = SLOT_W + WORD_W;
  localparam int unsigned KEY_WORD_W = 64;
  localparam int unsigned KEY_W      = KEY_WORD_W * KEY_WORDS;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned HASH_CNT_W = $clog2(HASH_W);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TTL_W      = 31;
  localparam int unsigned VALUE_W    = 32;

  localparam logic [CFG_W-1:0] MAX_SLOTS_N = CFG_W'(MAX_SLOTS);
  localparam logic [CFG_W-1:0] MIN_SLOTS_N = CFG_W'(MIN_SLOTS);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_STORE  = 1'b1;

  typedef struct packed {
    logic              key_we;
    logic              meta_we;
    logic              valid_we;
    logic              valid_bit;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } mem_wr_t;

  typedef struct packed {
    logic              key_re;
    logic              meta_re;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } mem_rd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_status_t;

  // clamp the configured count into the legal range; zero selects the maximum
  function automatic logic [CFG_W-1:0] eff_slots(input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0] r;
    r = n;
    if (n == '0 || n > MAX_SLOTS_N) begin
      r = MAX_SLOTS_N;
    end else if (n < MIN_SLOTS_N) begin
      r = MIN_SLOTS_N;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dmtc_req_if.sv
// request channel of the ttl verdict cache: valid, ready and one request word
// depends on dmtc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dmtc_req_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [dmtc_pkg::KEY_WORD_W-1:0]     key_word0;
  logic [dmtc_pkg::KEY_WORD_W-1:0]     key_word1;
  logic [dmtc_pkg::KEY_WORD_W-1:0]     key_word2;
  logic [dmtc_pkg::KEY_WORD_W-1:0]     key_word3;
  logic [dmtc_pkg::TIME_W-1:0]         now_ms;
  logic [dmtc_pkg::VALUE_W-1:0]        value_in;
  logic [dmtc_pkg::TTL_W-1:0]          ttl_ms;

  modport source (
    output valid, cmd, key_word0, key_word1, key_word2, key_word3, now_ms, value_in, ttl_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, key_word0, key_word1, key_word2, key_word3, now_ms, value_in, ttl_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/dmtc_rsp_if.sv
// response channel of the ttl verdict cache: valid, ready and one result word
// depends on dmtc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dmtc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [dmtc_pkg::VALUE_W-1:0] value_out;

  modport source (
    output valid, hit, value_out,
    input  ready
  );
  modport sink (
    input  valid, hit, value_out,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/dmtc_serial_unit.sv
// bit-serial slot index (hash mod slot count) and deadline (now + ttl)
// one bit per cycle; depends on dmtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmtc_serial_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [dmtc_pkg::CFG_W-1:0]        slots_i,
  input  wire logic [dmtc_pkg::HASH_W-1:0]       hash_i,
  input  wire logic [dmtc_pkg::TIME_W-1:0]       now_i,
  input  wire logic [dmtc_pkg::TTL_W-1:0]        ttl_i,
  output dmtc_pkg::ser_status_t                  status_o,
  output logic [dmtc_pkg::SLOT_W-1:0]            slot_o,
  output logic [dmtc_pkg::TIME_W-1:0]            deadline_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [dmtc_pkg::HASH_CNT_W-1:0]     cnt_q, cnt_d;
  logic [dmtc_pkg::CFG_W-1:0]          n_q, n_d;
  logic [dmtc_pkg::HASH_W-1:0]         hash_q, hash_d;
  logic [dmtc_pkg::SLOT_W-1:0]         rem_q, rem_d;
  logic [dmtc_pkg::TIME_W-1:0]         a_q, a_d;
  logic [dmtc_pkg::TIME_W-1:0]         b_q, b_d;
  logic [dmtc_pkg::TIME_W-1:0]         dl_q, dl_d;
  logic                                carry_q, carry_d;
  logic [dmtc_pkg::SLOT_W:0]           trial;
  logic                                sum_bit;

  assign trial   = {rem_q, hash_q[dmtc_pkg::HASH_W-1]};
  assign sum_bit = a_q[0] ^ b_q[0] ^ carry_q;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    n_d     = n_q;
    hash_d  = hash_q;
    rem_d   = rem_q;
    a_d     = a_q;
    b_d     = b_q;
    dl_d    = dl_q;
    carry_d = carry_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      n_d     = slots_i;
      hash_d  = hash_i;
      rem_d   = '0;
      a_d     = now_i;
      b_d     = {1'b0, ttl_i};
      carry_d = 1'b0;
    end else if (busy_q) begin
      // restoring remainder step
      if (trial >= n_q) begin
        rem_d = dmtc_pkg::SLOT_W'(trial - n_q);
      end else begin
        rem_d = dmtc_pkg::SLOT_W'(trial);
      end
      hash_d  = {hash_q[dmtc_pkg::HASH_W-2:0], 1'b0};
      // ripple add, lsb first
      dl_d    = {sum_bit, dl_q[dmtc_pkg::TIME_W-1:1]};
      carry_d = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));
      a_d     = {1'b0, a_q[dmtc_pkg::TIME_W-1:1]};
      b_d     = {1'b0, b_q[dmtc_pkg::TIME_W-1:1]};
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    hash_q  <= hash_d;
    rem_q   <= rem_d;
    a_q     <= a_d;
    b_q     <= b_d;
    dl_q    <= dl_d;
    carry_q <= carry_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign slot_o        = rem_q;
  assign deadline_o    = dl_q;

endmodule

`default_nettype wire

>>> rtl/core/dmtc_slot_mem.sv
// slot storage: key words, value, deadline and valid bit per slot
// single write and registered read per array; depends on dmtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmtc_slot_mem (
  input  wire logic                              clk_i,
  input  wire dmtc_pkg::mem_wr_t                 wr_i,
  input  wire logic [dmtc_pkg::KEY_WORD_W-1:0]   wr_key_i,
  input  wire logic [dmtc_pkg::VALUE_W-1:0]      wr_value_i,
  input  wire logic [dmtc_pkg::TIME_W-1:0]       wr_deadline_i,
  input  wire dmtc_pkg::mem_rd_t                 rd_i,
  output logic [dmtc_pkg::KEY_WORD_W-1:0]        rd_key_o,
  output logic                                   rd_valid_o,
  output logic [dmtc_pkg::VALUE_W-1:0]           rd_value_o,
  output logic [dmtc_pkg::TIME_W-1:0]            rd_deadline_o
);

  logic [dmtc_pkg::KEY_WORD_W-1:0] key_mem   [dmtc_pkg::KEY_DEPTH];
  logic [dmtc_pkg::VALUE_W-1:0]    value_mem [dmtc_pkg::MAX_SLOTS];
  logic [dmtc_pkg::TIME_W-1:0]     dl_mem    [dmtc_pkg::MAX_SLOTS];
  logic                            valid_mem [dmtc_pkg::MAX_SLOTS];

  logic [dmtc_pkg::KEY_AW-1:0] wr_key_addr;
  logic [dmtc_pkg::KEY_AW-1:0] rd_key_addr;

  assign wr_key_addr = {wr_i.slot, wr_i.word};
  assign rd_key_addr = {rd_i.slot, rd_i.word};

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_key_addr] <= wr_key_i;
    end
    if (rd_i.key_re) begin
      rd_key_o <= key_mem[rd_key_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.meta_we) begin
      value_mem[wr_i.slot] <= wr_value_i;
      dl_mem[wr_i.slot]    <= wr_deadline_i;
    end
    if (rd_i.meta_re) begin
      rd_value_o    <= value_mem[rd_i.slot];
      rd_deadline_o <= dl_mem[rd_i.slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid_we) begin
      valid_mem[wr_i.slot] <= wr_i.valid_bit;
    end
    if (rd_i.meta_re) begin
      rd_valid_o <= valid_mem[rd_i.slot];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/direct_mapped_ttl_verdict_cache.sv
// direct-mapped verdict cache with ttl expiry, 2048 slots, 256-bit keys
// depends on dmtc_pkg, dmtc_req_if, dmtc_rsp_if, dmtc_serial_unit, dmtc_slot_mem
//
// usage:
//   req_i carries one word per request: cmd (0 lookup, 1 store), four key
//   words, now_ms, value_in and ttl_ms; rsp_o returns one word per request
//   with hit and value_out (both zero for a store, a miss or an expired slot)
//   cfg_we_i/cfg_wdata_i set slots_in_use; write it only while idle
// timing:
//   one request at a time; a bit-serial unit gives the slot index and the
//   deadline after accept, then a lookup reads the four key words and a
//   store writes them; a zero-ttl store writes nothing and goes straight
//   to the result
//   the result sits in an output register, so the next request is taken
//   while an earlier result waits; a stalled receiver holds back only the
//   finish of the following request
// reset:
//   a clearing pass zeros the 2048 valid bits, one per cycle; req_i.ready
//   stays low until the pass ends, configuration writes are taken
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_ttl_verdict_cache (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  dmtc_req_if.sink                          req_i,
  dmtc_rsp_if.source                        rsp_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [dmtc_pkg::CFG_W-1:0]   cfg_wdata_i
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_READ  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [dmtc_pkg::CFG_W-1:0]      slots_q;
  logic [dmtc_pkg::SLOT_W-1:0]     clr_q, clr_d;
  logic [dmtc_pkg::WORD_W:0]       cnt_q, cnt_d;
  logic                            cmd_q, cmd_d;
  logic                            ttl_nz_q, ttl_nz_d;
  logic [dmtc_pkg::KEY_W-1:0]      key_sr_q, key_sr_d;
  logic [dmtc_pkg::TIME_W-1:0]     now_q, now_d;
  logic [dmtc_pkg::VALUE_W-1:0]    value_q, value_d;
  logic                            match_q, match_d;
  logic                            rsp_valid_q, rsp_valid_d;
  logic                            hit_q, hit_d;
  logic [dmtc_pkg::VALUE_W-1:0]    value_out_q, value_out_d;

  logic                            accept;
  logic                            ser_start;
  dmtc_pkg::ser_status_t           ser_status;
  logic [dmtc_pkg::SLOT_W-1:0]     slot;
  logic [dmtc_pkg::TIME_W-1:0]     deadline;
  dmtc_pkg::mem_wr_t               mem_wr;
  dmtc_pkg::mem_rd_t               mem_rd;
  logic [dmtc_pkg::KEY_WORD_W-1:0] rd_key;
  logic                            rd_valid;
  logic [dmtc_pkg::VALUE_W-1:0]    rd_value;
  logic [dmtc_pkg::TIME_W-1:0]     rd_deadline;
  logic [dmtc_pkg::TIME_W-1:0]     age;
  logic [dmtc_pkg::KEY_WORD_W-1:0] key_head;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign ser_start   = accept;
  assign key_head    = key_sr_q[dmtc_pkg::KEY_W-1 -: dmtc_pkg::KEY_WORD_W];
  assign age         = now_q - rd_deadline;

  dmtc_serial_unit u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ser_start),
    .slots_i    (dmtc_pkg::eff_slots(slots_q)),
    .hash_i     (req_i.key_word0[dmtc_pkg::KEY_WORD_W-1 -: dmtc_pkg::HASH_W]),
    .now_i      (req_i.now_ms),
    .ttl_i      (req_i.ttl_ms),
    .status_o   (ser_status),
    .slot_o     (slot),
    .deadline_o (deadline)
  );

  dmtc_slot_mem u_mem (
    .clk_i         (clk_i),
    .wr_i          (mem_wr),
    .wr_key_i      (key_head),
    .wr_value_i    (value_q),
    .wr_deadline_i (deadline),
    .rd_i          (mem_rd),
    .rd_key_o      (rd_key),
    .rd_valid_o    (rd_valid),
    .rd_value_o    (rd_value),
    .rd_deadline_o (rd_deadline)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    ttl_nz_d    = ttl_nz_q;
    key_sr_d    = key_sr_q;
    now_d       = now_q;
    value_d     = value_q;
    match_d     = match_q;
    rsp_valid_d = rsp_valid_q;
    hit_d       = hit_q;
    value_out_d = value_out_q;

    mem_wr           = '0;
    mem_wr.slot      = slot;
    mem_wr.word      = cnt_q[dmtc_pkg::WORD_W-1:0];
    mem_rd           = '0;
    mem_rd.slot      = slot;
    mem_rd.word      = cnt_q[dmtc_pkg::WORD_W-1:0];

    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_wr.valid_we  = 1'b1;
        mem_wr.valid_bit = 1'b0;
        mem_wr.slot      = clr_q;
        clr_d            = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = req_i.cmd;
          ttl_nz_d = (req_i.ttl_ms != '0);
          key_sr_d = {req_i.key_word0, req_i.key_word1, req_i.key_word2, req_i.key_word3};
          now_d    = req_i.now_ms;
          value_d  = req_i.value_in;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d   = '0;
        match_d = 1'b1;
        if (ser_status.done) begin
          if (cmd_q == dmtc_pkg::CMD_STORE) begin
            state_d = ttl_nz_q ? ST_WRITE : ST_FIN;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_WRITE: begin
        mem_wr.key_we = 1'b1;
        if (cnt_q == '0) begin
          mem_wr.meta_we   = 1'b1;
          mem_wr.valid_we  = 1'b1;
          mem_wr.valid_bit = 1'b1;
        end
        key_sr_d = {key_sr_q[dmtc_pkg::KEY_W-dmtc_pkg::KEY_WORD_W-1:0],
                    {dmtc_pkg::KEY_WORD_W{1'b0}}};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == (dmtc_pkg::WORD_W + 1)'(dmtc_pkg::KEY_WORDS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_READ: begin
        if (cnt_q < (dmtc_pkg::WORD_W + 1)'(dmtc_pkg::KEY_WORDS)) begin
          mem_rd.key_re = 1'b1;
        end
        if (cnt_q == '0) begin
          mem_rd.meta_re = 1'b1;
        end else begin
          // data of the word issued last cycle
          if (rd_key != key_head) begin
            match_d = 1'b0;
          end
          key_sr_d = {key_sr_q[dmtc_pkg::KEY_W-dmtc_pkg::KEY_WORD_W-1:0],
                      {dmtc_pkg::KEY_WORD_W{1'b0}}};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (dmtc_pkg::WORD_W + 1)'(dmtc_pkg::KEY_WORDS)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          if (cmd_q == dmtc_pkg::CMD_LOOKUP && rd_valid && match_q
              && age[dmtc_pkg::TIME_W-1]) begin
            hit_d       = 1'b1;
            value_out_d = rd_value;
          end else begin
            hit_d       = 1'b0;
            value_out_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      slots_q     <= dmtc_pkg::MAX_SLOTS_N;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ttl_nz_q    <= ttl_nz_d;
    key_sr_q    <= key_sr_d;
    now_q       <= now_d;
    value_q     <= value_d;
    match_q     <= match_d;
    hit_q       <= hit_d;
    value_out_q <= value_out_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = hit_q;
  assign rsp_o.value_out = value_out_q;

endmodule

`default_nettype wire

>>> dv/tb_direct_mapped_ttl_verdict_cache.sv
// self-checking testbench for direct_mapped_ttl_verdict_cache: a verdict scoreboard
// predicts hit and value_out per request word while both channels idle at random
// depends on dmtc_pkg, dmtc_req_if, dmtc_rsp_if and the cache rtl
`timescale 1ns / 1ps

typedef struct packed {
  logic        cmd;
  logic [255:0] key;
  logic [31:0] now_ms;
  logic [31:0] value_in;
  logic [30:0] ttl_ms;
} verdict_req_t;

typedef struct packed {
  logic        hit;
  logic [31:0] value;
} verdict_t;

class verdict_scoreboard;
  logic [11:0]  slot_count;
  bit           line_valid[dmtc_pkg::MAX_SLOTS];
  logic [255:0] line_key[dmtc_pkg::MAX_SLOTS];
  logic [31:0]  line_deadline[dmtc_pkg::MAX_SLOTS];
  logic [31:0]  line_value[dmtc_pkg::MAX_SLOTS];
  verdict_t     pending_verdicts[$];
  int unsigned  mismatches;
  int unsigned  words_seen;

  function new();
    slot_count = dmtc_pkg::MAX_SLOTS_N;
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    mismatches = 0;
    words_seen = 0;
  endfunction

  function int unsigned active_slots();
    if (slot_count == 0 || slot_count > dmtc_pkg::MAX_SLOTS) return dmtc_pkg::MAX_SLOTS;
    if (slot_count < dmtc_pkg::MIN_SLOTS) return dmtc_pkg::MIN_SLOTS;
    return slot_count;
  endfunction

  function void note_request(verdict_req_t r);
    verdict_t    v;
    int unsigned s;
    logic [31:0] age;
    v.hit = 1'b0;
    v.value = '0;
    s = r.key[255:224] % active_slots();
    if (r.cmd == dmtc_pkg::CMD_STORE) begin
      if (r.ttl_ms != 0) begin
        line_key[s] = r.key;
        line_value[s] = r.value_in;
        line_deadline[s] = r.now_ms + {1'b0, r.ttl_ms};
        line_valid[s] = 1'b1;
      end
    end else if (line_valid[s] && line_key[s] == r.key) begin
      // live while now - deadline is negative
      age = r.now_ms - line_deadline[s];
      if (age[31]) begin
        v.hit = 1'b1;
        v.value = line_value[s];
      end
    end
    pending_verdicts.push_back(v);
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 40) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_result(logic hit, logic [31:0] value);
    verdict_t want;
    words_seen++;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("word %0d unexpected, hit=%b value=%h", words_seen, hit, value));
      return;
    end
    want = pending_verdicts.pop_front();
    if (hit !== want.hit)
      report_mismatch($sformatf("word %0d hit %b, want %b", words_seen, hit, want.hit));
    if (value !== want.value)
      report_mismatch($sformatf("word %0d value_out %h, want %h", words_seen, value, want.value));
  endtask
endclass

module tb_direct_mapped_ttl_verdict_cache;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;

  dmtc_req_if req_if ();
  dmtc_rsp_if rsp_if ();

  direct_mapped_ttl_verdict_cache uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  verdict_scoreboard board = new();

  logic [255:0] recent_keys[$];
  logic [31:0]  clock_ms;
  bit           req_up;
  int unsigned  burst_left;
  bit           sink_open;
  int unsigned  stall_run;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [255:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic verdict_req_t make_req(logic cmd, logic [255:0] key, logic [31:0] now,
                                            logic [31:0] value, logic [30:0] ttl);
    verdict_req_t r;
    r.cmd = cmd;
    r.key = key;
    r.now_ms = now;
    r.value_in = value;
    r.ttl_ms = ttl;
    return r;
  endfunction

  function automatic verdict_req_t random_request();
    verdict_req_t r;
    logic [255:0] k;
    int unsigned  pick;
    int unsigned  way;
    clock_ms += 32'($urandom_range(120));
    r.now_ms = ($urandom_range(19) == 0) ? $urandom : clock_ms;
    r.value_in = $urandom;
    case ($urandom_range(19))
      0: r.ttl_ms = '0;
      1: r.ttl_ms = 31'h7FFF_FFFF;
      2: r.ttl_ms = 31'($urandom);
      default: r.ttl_ms = 31'($urandom_range(4000, 1));
    endcase
    pick = $urandom_range(99);
    way = $urandom_range(9);
    k = random_key();
    if (pick < 45) begin
      r.cmd = dmtc_pkg::CMD_STORE;
      if (recent_keys.size() != 0 && way >= 6) begin
        if (way >= 8) begin
          // same slot, different key
          k[255:224] = recent_keys[$urandom_range(recent_keys.size() - 1)][255:224]
                       + 32'(board.active_slots() * $urandom_range(3, 1));
        end else begin
          k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        end
      end
      recent_keys.push_back(k);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end else begin
      r.cmd = dmtc_pkg::CMD_LOOKUP;
      if (recent_keys.size() != 0 && way < 8) begin
        k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (way == 7) k[$urandom_range(255)] ^= 1'b1;
      end
    end
    r.key = k;
    return r;
  endfunction

  task automatic send_request(verdict_req_t r);
    req_if.valid     <= 1'b1;
    req_if.cmd       <= r.cmd;
    req_if.key_word0 <= r.key[255:192];
    req_if.key_word1 <= r.key[191:128];
    req_if.key_word2 <= r.key[127:64];
    req_if.key_word3 <= r.key[63:0];
    req_if.now_ms    <= r.now_ms;
    req_if.value_in  <= r.value_in;
    req_if.ttl_ms    <= r.ttl_ms;
    req_up = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
      repeat ($urandom_range(45, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(7) == 0) ? 60 : $urandom_range(12);
    end
  endtask

  task automatic drain();
    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (board.pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slot_count(logic [11:0] count);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.slot_count = count;
  endtask

  task automatic run_directed();
    logic [255:0] key_a;
    logic [255:0] key_b;
    logic [255:0] key_c;
    logic [255:0] key_d;
    logic [255:0] key_e;
    key_a = '0;
    key_b = '1;
    key_c = {32'h7FFF_FFFF, 32'h1234_5678, random_key()};
    key_d = {32'h0000_0800, 32'h0, 192'h0};
    key_e = {32'h0000_0001, 32'hFFFF_0000, 64'h0123_4567_89AB_CDEF, 128'h0};
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_a, 32'h0, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0));
    // deadline one past now
    send_request(make_req(dmtc_pkg::CMD_STORE, key_a, 32'h0, 32'hFFFF_FFFF, 31'h1));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_a, 32'h0, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_a, 32'h1, 32'h0, 31'h0));
    // longest ttl across the wrap
    send_request(make_req(dmtc_pkg::CMD_STORE, key_b, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
                          31'h7FFF_FFFF));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b, 32'hFFFF_FFFF, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b, 32'h7FFF_FFFD, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b, 32'h7FFF_FFFE, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b ^ 256'h1, 32'hFFFF_FFFF, 32'h0, 31'h0));
    // zero ttl store is dropped
    send_request(make_req(dmtc_pkg::CMD_STORE, key_c, 32'h0, 32'h1, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b, 32'h0, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_c, 32'h0, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_STORE, key_d, 32'd10, 32'h5, 31'd100));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_a, 32'h0, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_d, 32'd109, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_d, 32'd110, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_STORE, key_e, 32'hFFFF_FFF0, 32'h0, 31'h20));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_e, 32'h5, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_e, 32'h10, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_e ^ {128'h0, 64'h8000, 64'h0}, 32'h5,
                          32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_STORE, key_c, 32'h0, 32'hFFFF_0000, 31'd50));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_b, 32'h0, 32'h0, 31'h0));
    send_request(make_req(dmtc_pkg::CMD_LOOKUP, key_c, 32'h0, 32'h0, 31'h0));
  endtask

  // result side with its own stall pattern
  initial begin
    rsp_if.ready <= 1'b0;
    sink_open = 1'b0;
    stall_run = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.hit, rsp_if.value_out);
      if (stall_run == 0) begin
        sink_open = !sink_open;
        stall_run = sink_open ? $urandom_range(30, 1) : $urandom_range(14, 1);
        if (sink_open && $urandom_range(5) == 0) stall_run = 400;
      end
      stall_run--;
      rsp_if.ready <= sink_open;
    end
  end

  initial begin
    int unsigned slot_plan[10];
    slot_plan = '{64, 0, 37, 4095, 2048, 1000, 65, 2049, 1, 2047};
    slot_plan[9] = ($urandom_range(1) == 0) ? 2047 : $urandom_range(4095);
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    req_if.valid     <= 1'b0;
    req_if.cmd       <= dmtc_pkg::CMD_LOOKUP;
    req_if.key_word0 <= '0;
    req_if.key_word1 <= '0;
    req_if.key_word2 <= '0;
    req_if.key_word3 <= '0;
    req_if.now_ms    <= '0;
    req_if.value_in  <= '0;
    req_if.ttl_ms    <= '0;
    req_up = 1'b0;
    burst_left = 0;
    clock_ms = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      write_slot_count(12'(slot_plan[phase]));
      clock_ms = phase[0] ? 32'hFFFF_FFFF - 32'($urandom_range(6000)) : $urandom;
      repeat (190) send_request(random_request());
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (board.pending_verdicts.size() != 0)
      board.report_mismatch($sformatf("%0d words never came", board.pending_verdicts.size()));
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
